// ===== design/clns_pkg.sv =====
// Shared types, controller codes and init sequence table for the LCD nibble sequencer.
`timescale 1ns / 1ps
`default_nettype none
package clns_pkg;

  // Request codes on in_req_type
  typedef enum logic [1:0] {
    REQ_INIT  = 2'd0,
    REQ_CMD   = 2'd1,
    REQ_DATA  = 2'd2,
    REQ_LIGHT = 2'd3
  } req_code_t;

  // Configuration register indexes
  localparam logic CFG_FONT_5X10 = 1'b0;
  localparam logic CFG_TWO_LINES = 1'b1;

  // Controller command codes
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_DISPLAY  = 8'h08;
  localparam logic [7:0] CMD_DISP_ALL = 8'h0F; // display on, cursor, blink
  localparam logic [7:0] CMD_FUNC     = 8'h20;
  localparam logic [7:0] CMD_FUNC_DL  = 8'h30; // function set, 8-bit bus

  // Hold times in microseconds
  localparam int HOLD_W = 14;
  localparam logic [HOLD_W-1:0] HOLD_NONE   = 14'd0;
  localparam logic [HOLD_W-1:0] HOLD_PULSE  = 14'd1;
  localparam logic [HOLD_W-1:0] HOLD_EXEC   = HOLD_W'(1 + 39);
  localparam logic [HOLD_W-1:0] HOLD_CLEAR  = HOLD_W'(1 + 39 + 1530);
  localparam logic [HOLD_W-1:0] HOLD_BOOT   = HOLD_W'(15000);
  localparam logic [HOLD_W-1:0] HOLD_RESET2 = HOLD_W'(1 + 4100);
  localparam logic [HOLD_W-1:0] HOLD_RESET3 = HOLD_W'(1 + 61);

  localparam logic [4:0] INIT_LAST_STEP = 5'd24;
  localparam logic [4:0] BYTE_LAST_STEP = 5'd3;

  typedef enum logic [1:0] {
    OP_INIT,
    OP_BYTE,
    OP_LIGHT
  } op_kind_t;

  // Classified request, as queued between front and back
  typedef struct packed {
    op_kind_t   kind;
    logic       rs;
    logic [7:0] byte_val;
    logic       clear;
    logic       light;
    logic [3:0] fs_low;  // low nibble of function set: N, F, 0, 0
  } op_t;

  typedef struct packed {
    logic [3:0]        nib;
    logic              en;
    logic [HOLD_W-1:0] hold;
  } pin_state_t;

  // Nibble states of the init run, steps 1..24 (step 0 is the backlight state)
  function automatic pin_state_t init_state(input logic [4:0] step, input logic [3:0] fs_low);
    pin_state_t ps;
    ps.en   = step[0];
    ps.hold = HOLD_PULSE;
    ps.nib  = 4'h0;
    case (step)
      5'd1, 5'd3, 5'd5: ps.nib = CMD_FUNC_DL[7:4];
      5'd2:             begin ps.nib = CMD_FUNC_DL[7:4]; ps.hold = HOLD_RESET2; end
      5'd4:             begin ps.nib = CMD_FUNC_DL[7:4]; ps.hold = HOLD_RESET3; end
      5'd6:             ps.nib = CMD_FUNC_DL[7:4];
      5'd7, 5'd8:       ps.nib = CMD_FUNC[7:4];
      5'd9, 5'd10:      ps.nib = CMD_FUNC[7:4];
      5'd11:            ps.nib = fs_low;
      5'd12:            begin ps.nib = fs_low; ps.hold = HOLD_EXEC; end
      5'd13, 5'd14:     ps.nib = CMD_DISPLAY[7:4];
      5'd15:            ps.nib = CMD_DISPLAY[3:0];
      5'd16:            begin ps.nib = CMD_DISPLAY[3:0]; ps.hold = HOLD_EXEC; end
      5'd17, 5'd18:     ps.nib = CMD_CLEAR[7:4];
      5'd19:            ps.nib = CMD_CLEAR[3:0];
      5'd20:            begin ps.nib = CMD_CLEAR[3:0]; ps.hold = HOLD_CLEAR; end
      5'd21, 5'd22:     ps.nib = CMD_DISP_ALL[7:4];
      5'd23:            ps.nib = CMD_DISP_ALL[3:0];
      5'd24:            begin ps.nib = CMD_DISP_ALL[3:0]; ps.hold = HOLD_EXEC; end
      default:          ps.hold = HOLD_NONE;
    endcase
    return ps;
  endfunction

endpackage
`default_nettype wire

// ===== design/clns_front.sv =====
// Front end: accepts requests, holds the font and line registers, classifies requests.
`timescale 1ns / 1ps
`default_nettype none
module clns_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   in_req_type,
  input  wire logic [7:0]   in_value,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic         cfg_data,
  input  wire logic         q_full,
  output logic              q_push,
  output clns_pkg::op_t     q_op
);
  import clns_pkg::*;

  logic font_5x10_r, two_lines_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign q_push    = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_5x10_r <= 1'b0;
      two_lines_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FONT_5X10: font_5x10_r <= cfg_data;
        CFG_TWO_LINES: two_lines_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    q_op          = '0;
    q_op.byte_val = in_value;
    q_op.light    = in_value[0];
    q_op.fs_low   = {two_lines_r, font_5x10_r, 2'b00};
    unique case (in_req_type)
      REQ_INIT:  q_op.kind = OP_INIT;
      REQ_CMD: begin
        q_op.kind  = OP_BYTE;
        q_op.clear = (in_value == CMD_CLEAR);
      end
      REQ_DATA: begin
        q_op.kind = OP_BYTE;
        q_op.rs   = 1'b1;
      end
      REQ_LIGHT: q_op.kind = OP_LIGHT;
      default:   q_op.kind = OP_LIGHT;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/clns_fifo.sv =====
// Two-entry queue of classified requests between front and back.
`timescale 1ns / 1ps
`default_nettype none
module clns_fifo (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire clns_pkg::op_t push_op,
  output logic          full,
  input  wire logic     pop,
  output clns_pkg::op_t pop_op,
  output logic          empty
);
  import clns_pkg::*;

  op_t        mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full   = (count_r == 2'd2);
  assign empty  = (count_r == 2'd0);
  assign pop_op = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/clns_back.sv =====
// Back end: steps through the pin states of one request into the output register.
`timescale 1ns / 1ps
`default_nettype none
module clns_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_empty,
  input  wire clns_pkg::op_t q_op,
  output logic              q_pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              out_reg_select,
  output logic [3:0]        out_nibble,
  output logic              out_enable,
  output logic              out_backlight,
  output logic [13:0]       out_hold_us,
  output logic              out_last
);
  import clns_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [4:0]        step_r, step_nxt;
  logic              rs_level_r, rs_level_nxt;
  logic [3:0]        nib_level_r, nib_level_nxt;
  logic              bl_level_r, bl_level_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_rs_r, out_rs_nxt;
  logic [3:0]        out_nib_r, out_nib_nxt;
  logic              out_en_r, out_en_nxt;
  logic              out_bl_r, out_bl_nxt;
  logic [HOLD_W-1:0] out_hold_r, out_hold_nxt;
  logic              out_last_r, out_last_nxt;

  pin_state_t ps;
  logic       light_state, last_state, advance;

  assign q_pop   = (state_r == ST_IDLE) && !q_empty;
  assign advance = (state_r == ST_RUN) && (!out_valid_r || out_ready);

  // Pin state for the current step
  always_comb begin
    ps          = '0;
    light_state = 1'b0;
    last_state  = 1'b0;
    unique case (op_r.kind)
      OP_INIT: begin
        ps          = init_state(step_r, op_r.fs_low);
        light_state = (step_r == 5'd0);
        if (light_state) ps.hold = HOLD_BOOT;
        last_state  = (step_r == INIT_LAST_STEP);
      end
      OP_BYTE: begin
        ps.nib     = step_r[1] ? op_r.byte_val[3:0] : op_r.byte_val[7:4];
        ps.en      = !step_r[0];
        last_state = (step_r == BYTE_LAST_STEP);
        ps.hold    = last_state ? (op_r.clear ? HOLD_CLEAR : HOLD_EXEC) : HOLD_PULSE;
      end
      OP_LIGHT: begin
        light_state = 1'b1;
        last_state  = 1'b1;
        ps.hold     = HOLD_NONE;
      end
      default: begin
        light_state = 1'b1;
        last_state  = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    step_nxt      = step_r;
    rs_level_nxt  = rs_level_r;
    nib_level_nxt = nib_level_r;
    bl_level_nxt  = bl_level_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rs_nxt    = out_rs_r;
    out_nib_nxt   = out_nib_r;
    out_en_nxt    = out_en_r;
    out_bl_nxt    = out_bl_r;
    out_hold_nxt  = out_hold_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          op_nxt    = q_op;
          step_nxt  = 5'd0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          out_en_nxt    = ps.en;
          out_hold_nxt  = ps.hold;
          out_last_nxt  = last_state;
          if (light_state) begin
            out_rs_nxt   = rs_level_r;
            out_nib_nxt  = nib_level_r;
            out_bl_nxt   = op_r.light;
            bl_level_nxt = op_r.light;
          end else begin
            out_rs_nxt    = op_r.rs;
            out_nib_nxt   = ps.nib;
            out_bl_nxt    = bl_level_r;
            rs_level_nxt  = op_r.rs;
            nib_level_nxt = ps.nib;
          end
          step_nxt = step_r + 5'd1;
          if (last_state) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rs_level_r  <= 1'b0;
      nib_level_r <= 4'h0;
      bl_level_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rs_level_r  <= rs_level_nxt;
      nib_level_r <= nib_level_nxt;
      bl_level_r  <= bl_level_nxt;
      op_r        <= op_nxt;
      step_r      <= step_nxt;
      out_rs_r    <= out_rs_nxt;
      out_nib_r   <= out_nib_nxt;
      out_en_r    <= out_en_nxt;
      out_bl_r    <= out_bl_nxt;
      out_hold_r  <= out_hold_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reg_select = out_rs_r;
  assign out_nibble     = out_nib_r;
  assign out_enable     = out_en_r;
  assign out_backlight  = out_bl_r;
  assign out_hold_us    = out_hold_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire

// ===== design/char_lcd_nibble_sequencer_core.sv =====
// Top level of the character LCD nibble sequencer (4-bit bus controller driver).
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_req_type[1:0], in_value[7:0]
//   out_     output     out_valid / out_ready  out_reg_select, out_nibble[3:0],
//                                              out_enable, out_backlight,
//                                              out_hold_us[13:0], out_last
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Sequencing: the back-end sequencer issues one pin state per cycle while
//   out_ready stays high, and after the last pin state of each request it
//   returns to its idle state to load the next request from the queue.
// Reset: synchronous, active low; clears config, queue, sequencer and pin levels.
// Stalls: the two-entry request queue lets in_ requests land while out_ stalls;
//   in_ready drops only when the queue is full. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module char_lcd_nibble_sequencer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_reg_select,
  output logic [3:0]       out_nibble,
  output logic             out_enable,
  output logic             out_backlight,
  output logic [13:0]      out_hold_us,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data
);
  import clns_pkg::*;

  // Classified requests travel front -> queue -> back
  op_t  push_op, pop_op;
  logic push, pop, q_full, q_empty;

  clns_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_value    (in_value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .q_push      (push),
    .q_op        (push_op)
  );

  clns_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .pop_op  (pop_op),
    .empty   (q_empty)
  );

  // Back end owns the pin levels and the output register
  clns_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_op           (pop_op),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_reg_select (out_reg_select),
    .out_nibble     (out_nibble),
    .out_enable     (out_enable),
    .out_backlight  (out_backlight),
    .out_hold_us    (out_hold_us),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

// ===== design/clns_checker.sv =====
// Port-level checker for the LCD nibble sequencer, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module clns_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_reg_select,
  input wire logic [3:0]  out_nibble,
  input wire logic        out_enable,
  input wire logic        out_backlight,
  input wire logic [13:0] out_hold_us,
  input wire logic        out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_nibble) && $stable(out_hold_us)
      && $stable(out_enable) && $stable(out_last) && $stable(out_reg_select)
      && $stable(out_backlight))
    else $error("stalled output changed");

  a_pulse_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_enable |-> out_hold_us == 14'd1 && !out_last)
    else $error("enable high state must be a 1 us non-final pulse");

  a_last_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !out_enable)
    else $error("final state left enable high");

  a_boot_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hold_us == 14'd15000 |-> !out_enable && !out_last)
    else $error("boot wait state malformed");

endmodule

bind char_lcd_nibble_sequencer_core clns_checker u_clns_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_reg_select (out_reg_select),
  .out_nibble     (out_nibble),
  .out_enable     (out_enable),
  .out_backlight  (out_backlight),
  .out_hold_us    (out_hold_us),
  .out_last       (out_last)
);
`default_nettype wire
